[rtl/rstt_pkg.sv]
// Package for the repeating software timer table.
// Holds sizes, request/result codes and the slot record type.
// No dependencies; every other file in rtl/ uses it.
package rstt_pkg;

    // Default sizes
    localparam int NumSlots   = 16;
    localparam int TagWidth   = 16;
    localparam int MaxResults = 16;

    // Fixed field widths on the channels
    localparam int CountW  = 32;
    localparam int OutTagW = 16;
    localparam int NresW   = $clog2(MaxResults + 1);

    // Request kinds
    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Result status codes
    localparam logic STATUS_FIRED  = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // Slot record, the tag travels beside it at its own width
    typedef struct packed {
        logic              valid;
        logic [CountW-1:0] remaining;
        logic [CountW-1:0] period;
        logic [CountW-1:0] repeats;
    } t_slot;

endpackage

[rtl/rstt_req_if.sv]
// Request channel of the timer table: add or tick requests.
// Depends on rstt_pkg for field widths.
interface rstt_req_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [rstt_pkg::CountW-1:0] period;
    logic [rstt_pkg::CountW-1:0] repeat_count;
    logic [rstt_pkg::OutTagW-1:0] tag;

    modport source (output valid, kind, period, repeat_count, tag, input ready);
    modport sink   (input valid, kind, period, repeat_count, tag, output ready);
endinterface

[rtl/rstt_res_if.sv]
// Result channel of the timer table: fired or rejected tags.
// Depends on rstt_pkg for field widths.
interface rstt_res_if;
    logic                         valid;
    logic                         ready;
    logic [rstt_pkg::OutTagW-1:0] fired_tag;
    logic                         status;
    logic                         last;

    modport source (output valid, fired_tag, status, last, input ready);
    modport sink   (input valid, fired_tag, status, last, output ready);
endinterface

[rtl/repeating_software_timer_table.sv]
// Repeating software timer table: a ring of TIMER_SLOTS slot cells.
// An add or tick walks the ring once, visiting every slot at the head; a held
// firing or rejection is then flushed through the output stage as the last
// result. A zero-period add with a nonzero repeat count goes straight to the
// flush. A new request is taken only once the previous one is finished; the
// walk and flush stall while the result channel stalls. Reset (synchronous, active low)
// clears all slot valid bits and the sequencer; slot payload is not reset.
module repeating_software_timer_table #(
    parameter int TIMER_SLOTS = rstt_pkg::NumSlots,
    parameter int TAG_WIDTH   = rstt_pkg::TagWidth
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rstt_req_if.sink   i_req,
    rstt_res_if.source o_res
);

    rstt_pkg::t_slot      slot  [TIMER_SLOTS];
    logic [TAG_WIDTH-1:0] tag   [TIMER_SLOTS];
    rstt_pkg::t_slot      head_next;
    logic [TAG_WIDTH-1:0] head_tag_next;
    logic                 shift;

    // Sequencer working on the head of the ring
    rstt_walker #(
        .TIMER_SLOTS (TIMER_SLOTS),
        .TAG_WIDTH   (TAG_WIDTH)
    ) u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_res       (o_res),
        .i_head_slot (slot[0]),
        .i_head_tag  (tag[0]),
        .o_head_slot (head_next),
        .o_head_tag  (head_tag_next),
        .o_shift     (shift)
    );

    // Ring of slot cells: each takes its upper neighbour, the last the head
    for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
        if (g == TIMER_SLOTS - 1) begin : g_tail
            rstt_cell #(.TAG_WIDTH(TAG_WIDTH)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_slot  (head_next),
                .i_tag   (head_tag_next),
                .o_slot  (slot[g]),
                .o_tag   (tag[g])
            );
        end else begin : g_body
            rstt_cell #(.TAG_WIDTH(TAG_WIDTH)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_slot  (slot[g+1]),
                .i_tag   (tag[g+1]),
                .o_slot  (slot[g]),
                .o_tag   (tag[g])
            );
        end
    end

endmodule

[rtl/rstt_cell.sv]
// One timer slot of the ring: holds a slot record and its tag.
// Depends on rstt_pkg for the slot type.
module rstt_cell #(
    parameter int TAG_WIDTH = rstt_pkg::TagWidth
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_shift,
    input  rstt_pkg::t_slot      i_slot,
    input  logic [TAG_WIDTH-1:0] i_tag,
    output rstt_pkg::t_slot      o_slot,
    output logic [TAG_WIDTH-1:0] o_tag
);

    logic                          r_valid;
    logic [rstt_pkg::CountW-1:0]   r_remaining;
    logic [rstt_pkg::CountW-1:0]   r_period;
    logic [rstt_pkg::CountW-1:0]   r_repeats;
    logic [TAG_WIDTH-1:0]          r_tag;

    // Valid bit: cleared by reset, taken from the neighbour on a shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_slot.valid;
        end
    end

    // Slot payload: taken from the neighbour on a shift
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_remaining <= i_slot.remaining;
            r_period    <= i_slot.period;
            r_repeats   <= i_slot.repeats;
            r_tag       <= i_tag;
        end
    end

    assign o_slot = {r_valid, r_remaining, r_period, r_repeats};
    assign o_tag  = r_tag;

endmodule

[rtl/rstt_walker.sv]
// Sequencer of the timer table: rotates the ring once per add or tick request
// (not for a zero-period add), updates the head slot, and serialises firings
// through a pending and an output stage. Depends on rstt_pkg, rstt_req_if and rstt_res_if.
module rstt_walker #(
    parameter int TIMER_SLOTS = rstt_pkg::NumSlots,
    parameter int TAG_WIDTH   = rstt_pkg::TagWidth
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rstt_req_if.sink             i_req,
    rstt_res_if.source           o_res,
    input  rstt_pkg::t_slot      i_head_slot,
    input  logic [TAG_WIDTH-1:0] i_head_tag,
    output rstt_pkg::t_slot      o_head_slot,
    output logic [TAG_WIDTH-1:0] o_head_tag,
    output logic                 o_shift
);

    localparam int StepW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int NresW = rstt_pkg::NresW;
    localparam int CntW  = rstt_pkg::CountW;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0]           r_state,      n_state;
    logic [StepW-1:0]     r_step,       n_step;
    logic [NresW-1:0]     r_nres,       n_nres;
    logic                 r_placed,     n_placed;
    logic                 r_kind,       n_kind;
    logic [CntW-1:0]      r_period,     n_period;
    logic [CntW-1:0]      r_repeats,    n_repeats;
    logic [TAG_WIDTH-1:0] r_tag,        n_tag;
    logic                 r_pend_vld,   n_pend_vld;
    logic [TAG_WIDTH-1:0] r_pend_tag,   n_pend_tag;
    logic                 r_pend_stat,  n_pend_stat;
    logic                 r_out_vld;
    logic [TAG_WIDTH-1:0] r_out_tag;
    logic                 r_out_stat;
    logic                 r_out_last;

    logic                 out_free;
    logic                 push;
    logic [TAG_WIDTH-1:0] push_tag;
    logic                 push_stat;
    logic                 push_last;
    logic                 fire;
    logic                 emit;
    logic                 stall;
    logic                 place_now;
    logic [CntW-1:0]      rem_dec;
    logic [CntW-1:0]      rep_dec;

    assign out_free    = !r_out_vld || o_res.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign rem_dec     = i_head_slot.remaining - CntW'(1);
    assign rep_dec     = i_head_slot.repeats - CntW'(1);

    // Sequence the walk and update the head slot
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_nres      = r_nres;
        n_placed    = r_placed;
        n_kind      = r_kind;
        n_period    = r_period;
        n_repeats   = r_repeats;
        n_tag       = r_tag;
        n_pend_vld  = r_pend_vld;
        n_pend_tag  = r_pend_tag;
        n_pend_stat = r_pend_stat;
        o_head_slot = i_head_slot;
        o_head_tag  = i_head_tag;
        o_shift     = 1'b0;
        push        = 1'b0;
        push_tag    = r_pend_tag;
        push_stat   = r_pend_stat;
        push_last   = 1'b0;
        fire        = 1'b0;
        emit        = 1'b0;
        stall       = 1'b0;
        place_now   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_kind    = i_req.kind;
                    n_period  = i_req.period;
                    n_repeats = i_req.repeat_count;
                    n_tag     = TAG_WIDTH'(i_req.tag);
                    n_step    = '0;
                    n_nres    = '0;
                    n_placed  = 1'b0;
                    if (i_req.kind == rstt_pkg::KIND_ADD && i_req.period == '0) begin
                        // Zero period: fire once at once, or drop
                        if (i_req.repeat_count != '0) begin
                            n_pend_vld  = 1'b1;
                            n_pend_tag  = TAG_WIDTH'(i_req.tag);
                            n_pend_stat = rstt_pkg::STATUS_FIRED;
                            n_state     = S_FLUSH;
                        end
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end

            S_WALK: begin
                if (r_kind == rstt_pkg::KIND_TICK) begin
                    if (i_head_slot.valid) begin
                        if (rem_dec == '0) begin
                            fire = 1'b1;
                            o_head_slot.remaining = i_head_slot.period;
                            if (i_head_slot.repeats != '0) begin
                                o_head_slot.repeats = rep_dec;
                                if (rep_dec == '0) begin
                                    o_head_slot.valid = 1'b0;
                                end
                            end
                        end else begin
                            o_head_slot.remaining = rem_dec;
                        end
                    end
                end else if (!r_placed && !i_head_slot.valid) begin
                    // Load the lowest free slot
                    place_now             = 1'b1;
                    o_head_slot.valid     = 1'b1;
                    o_head_slot.remaining = r_period;
                    o_head_slot.period    = r_period;
                    o_head_slot.repeats   = r_repeats;
                    o_head_tag            = r_tag;
                end

                emit  = fire && (r_nres < NresW'(rstt_pkg::MaxResults));
                stall = emit && r_pend_vld && !out_free;

                if (!stall) begin
                    o_shift  = 1'b1;
                    n_placed = r_placed || place_now;
                    n_step   = r_step + StepW'(1);
                    if (emit) begin
                        // Release the older firing, hold the new one
                        push        = r_pend_vld;
                        n_pend_vld  = 1'b1;
                        n_pend_tag  = i_head_tag;
                        n_pend_stat = rstt_pkg::STATUS_FIRED;
                        n_nres      = r_nres + NresW'(1);
                    end
                    if (r_step == StepW'(TIMER_SLOTS - 1)) begin
                        n_step = '0;
                        if (r_kind == rstt_pkg::KIND_TICK) begin
                            n_state = n_pend_vld ? S_FLUSH : S_IDLE;
                        end else if (r_placed || place_now) begin
                            n_state = S_IDLE;
                        end else begin
                            n_pend_vld  = 1'b1;
                            n_pend_tag  = r_tag;
                            n_pend_stat = rstt_pkg::STATUS_REJECT;
                            n_state     = S_FLUSH;
                        end
                    end
                end
            end

            S_FLUSH: begin
                if (out_free) begin
                    push       = 1'b1;
                    push_last  = 1'b1;
                    n_pend_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= '0;
            r_nres     <= '0;
            r_placed   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_nres     <= n_nres;
            r_placed   <= n_placed;
            r_pend_vld <= n_pend_vld;
            if (push) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_period    <= n_period;
        r_repeats   <= n_repeats;
        r_tag       <= n_tag;
        r_pend_tag  <= n_pend_tag;
        r_pend_stat <= n_pend_stat;
        if (push) begin
            r_out_tag  <= push_tag;
            r_out_stat <= push_stat;
            r_out_last <= push_last;
        end
    end

    assign o_res.valid     = r_out_vld;
    assign o_res.fired_tag = rstt_pkg::OutTagW'(r_out_tag);
    assign o_res.status    = r_out_stat;
    assign o_res.last      = r_out_last;

`ifndef ASSERT_OFF
    a_idle_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_step == '0 && !r_pend_vld))
        else $error("idle with ring off home or a firing still held");

    a_flush_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |-> r_pend_vld)
        else $error("flush without a held result");

    a_nres_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= NresW'(rstt_pkg::MaxResults))
        else $error("result count beyond cap");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> out_free)
        else $error("result pushed into an occupied output stage");
`endif

endmodule

[dv/repeating_software_timer_table_tb.sv]
// Self-checking testbench for repeating_software_timer_table.
// Drives add/tick requests, predicts fired and rejected tags, checks each result.
// Depends on rstt_pkg, rstt_req_if and rstt_res_if from rtl/.
module repeating_software_timer_table_tb;

    localparam int SLOTS       = rstt_pkg::NumSlots;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 2 * SLOTS + 8;
    localparam int IDLE_PCT    = 36;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [rstt_pkg::OutTagW-1:0] tag;
        logic                         status;
        logic                         last;
    } t_timer_result;

    logic clk = 1'b0;
    logic rst_n;

    rstt_req_if req_if ();
    rstt_res_if res_if ();

    repeating_software_timer_table #(
        .TIMER_SLOTS (SLOTS),
        .TAG_WIDTH   (rstt_pkg::TagWidth)
    ) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // Shadow copy of the timer table
    logic                         slot_live   [SLOTS];
    logic [rstt_pkg::CountW-1:0]  slot_left   [SLOTS];
    logic [rstt_pkg::CountW-1:0]  slot_period [SLOTS];
    logic [rstt_pkg::CountW-1:0]  slot_runs   [SLOTS];
    logic [rstt_pkg::OutTagW-1:0] slot_tag    [SLOTS];

    t_timer_result pending_results[$];

    int  errors       = 0;
    int  cycle_count  = 0;
    int  hold_left    = 0;
    int  hold_req     = 0;
    int  hold_seen    = 0;
    bit  steady       = 1'b0;
    int  adds_sent    = 0;
    int  ticks_sent   = 0;
    int  fired_seen   = 0;
    int  rejects_seen = 0;
    int  lasting_left = 0;

    t_timer_result got_result;
    t_timer_result want_result;

    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still awaited", $time,
                     pending_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Drive result ready: long hold-off on request, then steady or random idling
    always @(posedge clk) begin
        if (hold_req != hold_seen) begin
            hold_seen    <= hold_req;
            hold_left    <= HOLD_CYCLES - 1;
            res_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            res_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (steady) begin
            res_if.ready <= 1'b1;
        end else begin
            res_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready) begin
            got_result = '{res_if.fired_tag, res_if.status, res_if.last};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, actual tag %h status %b last %b",
                         $time, got_result.tag, got_result.status, got_result.last);
                errors++;
            end else begin
                want_result = pending_results.pop_front();
                if (got_result !== want_result) begin
                    $display("%0t: mismatch, expected tag %h status %b last %b,",
                             $time, want_result.tag, want_result.status,
                             want_result.last);
                    $display("%0t:           actual tag %h status %b last %b",
                             $time, got_result.tag, got_result.status,
                             got_result.last);
                    errors++;
                end
                if (want_result.status == rstt_pkg::STATUS_REJECT)
                    rejects_seen++;
                else
                    fired_seen++;
            end
        end
    end

    function automatic int free_slot_count();
        int n;
        n = 0;
        for (int s = 0; s < SLOTS; s++)
            if (!slot_live[s])
                n++;
        return n;
    endfunction

    // Work out the results one accepted request causes and advance the shadow table
    function automatic void predict_timer_request(
        input logic                         kind,
        input logic [rstt_pkg::CountW-1:0]  period,
        input logic [rstt_pkg::CountW-1:0]  repeats,
        input logic [rstt_pkg::OutTagW-1:0] tag);
        t_timer_result fired[$];
        int            free_slot;
        free_slot = -1;
        if (kind == rstt_pkg::KIND_ADD) begin
            if (period == 0) begin
                // Zero period: fire at once unless the repeat count is zero
                if (repeats != 0)
                    fired.push_back('{tag, rstt_pkg::STATUS_FIRED, 1'b0});
            end else begin
                for (int s = SLOTS - 1; s >= 0; s--)
                    if (!slot_live[s])
                        free_slot = s;
                if (free_slot < 0) begin
                    fired.push_back('{tag, rstt_pkg::STATUS_REJECT, 1'b0});
                end else begin
                    slot_live[free_slot]   = 1'b1;
                    slot_left[free_slot]   = period;
                    slot_period[free_slot] = period;
                    slot_runs[free_slot]   = repeats;
                    slot_tag[free_slot]    = tag;
                end
            end
        end else begin
            // Count every live slot down, fire in slot order
            for (int s = 0; s < SLOTS; s++) begin
                if (slot_live[s]) begin
                    slot_left[s] = slot_left[s] - 1;
                    if (slot_left[s] == 0) begin
                        if (fired.size() < rstt_pkg::MaxResults)
                            fired.push_back('{slot_tag[s], rstt_pkg::STATUS_FIRED, 1'b0});
                        if (slot_runs[s] != 0) begin
                            slot_runs[s] = slot_runs[s] - 1;
                            if (slot_runs[s] == 0)
                                slot_live[s] = 1'b0;
                        end
                        if (slot_live[s])
                            slot_left[s] = slot_period[s];
                    end
                end
            end
        end
        for (int k = 0; k < fired.size(); k++) begin
            if (k == fired.size() - 1)
                fired[k].last = 1'b1;
            pending_results.push_back(fired[k]);
        end
    endfunction

    // Offer one request, at times after a random gap, and wait for it to be taken
    task automatic send_timer_request(input logic                         kind,
                                      input logic [rstt_pkg::CountW-1:0]  period,
                                      input logic [rstt_pkg::CountW-1:0]  repeats,
                                      input logic [rstt_pkg::OutTagW-1:0] tag);
        if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.kind         <= kind;
        req_if.period       <= period;
        req_if.repeat_count <= repeats;
        req_if.tag          <= tag;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        predict_timer_request(kind, period, repeats, tag);
        if (kind == rstt_pkg::KIND_ADD)
            adds_sent++;
        else
            ticks_sent++;
    endtask

    task automatic send_add(input logic [rstt_pkg::CountW-1:0]  period,
                            input logic [rstt_pkg::CountW-1:0]  repeats,
                            input logic [rstt_pkg::OutTagW-1:0] tag);
        send_timer_request(rstt_pkg::KIND_ADD, period, repeats, tag);
    endtask

    task automatic send_tick();
        send_timer_request(rstt_pkg::KIND_TICK, $urandom, $urandom,
                           rstt_pkg::OutTagW'($urandom_range(0, 65535)));
    endtask

    // Zero periods, extreme fields, multiple firings per tick, slot reuse
    task automatic test_special_cases();
        send_add(32'd0, 32'd0, 16'h1111);
        send_add(32'd0, 32'hFFFF_FFFF, 16'hFFFF);
        send_add(32'd0, 32'd1, 16'h0000);
        send_tick();
        send_add(32'd1, 32'd1, 16'h00A1);
        send_tick();
        send_add(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_add(32'd2, 32'd0, 16'h0B0B);
        send_add(32'd3, 32'd2, 16'h0C0C);
        send_add(32'd1, 32'd3, 16'h0D0D);
        repeat (6) send_tick();
        send_add(32'd1, 32'd1, 16'h0E0E);
        send_tick();
    endtask

    // Fill every free slot, then check rejection and a full-table tick
    task automatic test_table_full();
        int n;
        n = free_slot_count();
        for (int k = 0; k < n; k++)
            send_add(32'd4, 32'd1, 16'h2000 + 16'(k));
        send_add(32'd7, 32'd1, 16'hFADE);
        send_add(32'd0, 32'd5, 16'h0F0F);
        repeat (4) send_tick();
    endtask

    // Hold off the result side while ticks keep coming, so the block stalls
    task automatic test_backpressure();
        int n;
        n = free_slot_count();
        for (int k = 0; k < n; k++)
            send_add(32'd1, 32'd3, 16'h3000 + 16'(k));
        steady   = 1'b1;
        hold_req <= hold_req + 1;
        repeat (4) send_tick();
        steady   = 1'b0;
    endtask

    // Random adds and ticks, with a stretch of no idling in the middle
    task automatic test_random_traffic(input int count);
        logic [rstt_pkg::CountW-1:0] period;
        logic [rstt_pkg::CountW-1:0] repeats;
        int                          pick;
        lasting_left = 5;
        for (int k = 0; k < count; k++) begin
            steady = (k >= count / 3) && (k < count / 3 + 60);
            if ($urandom_range(0, 99) < 45) begin
                send_tick();
            end else begin
                // Long-lived timers never free their slot, so ration them
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    period  = 32'd0;
                    repeats = ($urandom_range(0, 99) < 30) ? 32'd0 : $urandom;
                end else begin
                    if (pick < 12 && lasting_left > 0) begin
                        period = $urandom;
                        lasting_left--;
                    end else begin
                        period = $urandom_range(1, 10);
                    end
                    pick = $urandom_range(0, 99);
                    if (pick < 10 && lasting_left > 0) begin
                        repeats = 32'd0;
                        lasting_left--;
                    end else if (pick < 15 && lasting_left > 0) begin
                        repeats = $urandom;
                        lasting_left--;
                    end else begin
                        repeats = $urandom_range(1, 5);
                    end
                end
                send_add(period, repeats, rstt_pkg::OutTagW'($urandom_range(0, 65535)));
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        req_if.valid        <= 1'b0;
        req_if.kind         <= rstt_pkg::KIND_TICK;
        req_if.period       <= '0;
        req_if.repeat_count <= '0;
        req_if.tag          <= '0;
        rst_n               <= 1'b0;
        for (int s = 0; s < SLOTS; s++)
            slot_live[s] = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_cases();
        test_table_full();
        test_backpressure();
        test_random_traffic(240);

        // Drop the request and drain outstanding results
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d adds and %0d ticks: %0d firings and %0d rejections checked,",
                 adds_sent, ticks_sent, fired_seen, rejects_seen);
        $display("including zero periods, a full table and a long result stall; %0d errors.",
                 errors);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
